FILE: src/sorted_key_table_with_group_defines.svh
// ============================================================================
// Sorted key table - assertion macros
// Shared check macros for the sorted key table RTL.
// ============================================================================
`ifndef SORTED_KEY_TABLE_WITH_GROUP_DEFINES_SVH
`define SORTED_KEY_TABLE_WITH_GROUP_DEFINES_SVH

// Property that must hold on every clock outside reset.
`define SKT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition on one clock implies a consequence on the next.
`define SKT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/skt_pkg.sv
// ============================================================================
// skt_pkg
// Types, widths and codes shared by the sorted key table modules.
// ============================================================================
package skt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BITS    = 16;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TAG_W  = 16;
    localparam int POS_W  = 7;
    localparam int HELD_W = 8;

    // command codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_GROUP  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] key;
        logic [15:0] group;
    } skt_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  position;
        logic [15:0]       group_out;
        logic [HELD_W-1:0] entries_held;
    } skt_res_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_W-1:0]    tag;
    } skt_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_cmp;
        logic shift_up;
        logic shift_down;
        logic shift_step;
        logic scan_step;
        logic write_new;
        logic finish;
    } skt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       srch_more;
        logic       hit;
        logic       full;
        logic       move_done;
    } skt_stat_t;

endpackage

FILE: src/skt_dpath.sv
// ============================================================================
// skt_dpath
// Entry memory, binary search registers, shift/scan engine, entry count and
// result register of the sorted key table.
// ============================================================================
`include "sorted_key_table_with_group_defines.svh"

module skt_dpath
    import skt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  skt_req_t request,
    input  skt_cmd_t cmd,
    output skt_stat_t stat,
    output skt_res_t result,
    output logic     done
);

    skt_entry_t mem [TABLE_DEPTH];
    skt_entry_t rdata_reg;

    logic [1:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [TAG_W-1:0]    grp_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [IDX_W-1:0]    mid_reg;
    logic                eq_reg;
    logic [TAG_W-1:0]    gq_reg;
    logic                full_reg;
    logic                up_reg;
    logic [IDX_W-1:0]    rp_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic                wv_reg;
    logic [IDX_W-1:0]    wa_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    fpos_reg;
    logic [CNT_W-1:0]    count_reg;
    skt_res_t            result_reg;
    logic                done_reg;

    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    mid_idx;
    logic [IDX_W-1:0]    mem_raddr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    skt_entry_t          mem_wdata;
    logic                removed;
    logic [CNT_W-1:0]    count_after;
    skt_res_t            res_next;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_idx = IDX_W'(mid_sum[CNT_W:1]);

    // memory ports
    always_comb
    begin
        mem_raddr = rp_reg;
        if (cmd.srch_rd)
        begin
            mem_raddr = mid_idx;
        end
        mem_we    = cmd.shift_step && wv_reg;
        mem_waddr = wa_reg;
        mem_wdata = rdata_reg;
        if (cmd.write_new)
        begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(lo_reg);
            mem_wdata = '{key: key_reg, tag: grp_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // result of the finished operation
    assign removed     = (op_reg == OP_REMOVE) && eq_reg;
    assign count_after = removed ? count_reg - CNT_W'(1) : count_reg;

    always_comb
    begin
        res_next.status       = ST_NOT_FOUND;
        res_next.position     = '0;
        res_next.group_out    = '0;
        res_next.entries_held = HELD_W'(count_after);
        case (op_reg)
            OP_INSERT:
            begin
                if (eq_reg)
                begin
                    res_next.status   = ST_DUPLICATE;
                    res_next.position = POS_W'(lo_reg);
                end
                else if (full_reg)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    res_next.status   = ST_OK;
                    res_next.position = POS_W'(lo_reg);
                end
            end
            OP_LOOKUP:
            begin
                if (eq_reg)
                begin
                    res_next.status    = ST_OK;
                    res_next.position  = POS_W'(lo_reg);
                    res_next.group_out = 16'(gq_reg);
                end
            end
            OP_REMOVE:
            begin
                if (eq_reg)
                begin
                    res_next.status   = ST_OK;
                    res_next.position = POS_W'(lo_reg);
                end
            end
            default:
            begin
                if (found_reg)
                begin
                    res_next.status   = ST_OK;
                    res_next.position = POS_W'(fpos_reg);
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            wv_reg    <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.write_new)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.finish)
            begin
                count_reg <= count_after;
            end

            if (cmd.load)
            begin
                rem_reg <= count_reg;
                wv_reg  <= 1'b0;
            end
            else if (cmd.shift_up)
            begin
                rem_reg <= count_reg - lo_reg;
                wv_reg  <= 1'b0;
            end
            else if (cmd.shift_down)
            begin
                rem_reg <= count_reg - lo_reg - CNT_W'(1);
                wv_reg  <= 1'b0;
            end
            else if (cmd.shift_step || cmd.scan_step)
            begin
                wv_reg <= (rem_reg != '0);
                if (rem_reg != '0)
                begin
                    rem_reg <= rem_reg - CNT_W'(1);
                end
            end
        end
    end

    // operation payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= request.command;
            key_reg   <= KEY_BITS'(request.key);
            grp_reg   <= request.group;
            lo_reg    <= '0;
            hi_reg    <= count_reg;
            eq_reg    <= 1'b0;
            full_reg  <= (count_reg >= CNT_W'(TABLE_DEPTH));
            rp_reg    <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.srch_rd)
        begin
            mid_reg <= mid_idx;
        end
        if (cmd.srch_cmp)
        begin
            if (rdata_reg.key < key_reg)
            begin
                lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
            end
            else
            begin
                // hi only ever lands on a probed index, so eq tracks the final lo
                hi_reg <= CNT_W'(mid_reg);
                eq_reg <= (rdata_reg.key == key_reg);
                gq_reg <= rdata_reg.tag;
            end
        end
        if (cmd.shift_up)
        begin
            up_reg <= 1'b1;
            rp_reg <= IDX_W'(count_reg - CNT_W'(1));
        end
        if (cmd.shift_down)
        begin
            up_reg <= 1'b0;
            rp_reg <= IDX_W'(lo_reg + CNT_W'(1));
        end
        if (cmd.shift_step && (rem_reg != '0))
        begin
            // read one source per cycle, write it back in the cycle after
            wa_reg <= up_reg ? rp_reg + IDX_W'(1) : rp_reg - IDX_W'(1);
            rp_reg <= up_reg ? rp_reg - IDX_W'(1) : rp_reg + IDX_W'(1);
        end
        if (cmd.scan_step)
        begin
            if (wv_reg && !found_reg && (rdata_reg.tag == grp_reg))
            begin
                found_reg <= 1'b1;
                fpos_reg  <= wa_reg;
            end
            if (rem_reg != '0)
            begin
                wa_reg <= rp_reg;
                rp_reg <= rp_reg + IDX_W'(1);
            end
        end
        if (cmd.finish)
        begin
            result_reg <= res_next;
        end
    end

    assign stat.op        = op_reg;
    assign stat.srch_more = (lo_reg < hi_reg);
    assign stat.hit       = eq_reg;
    assign stat.full      = full_reg;
    assign stat.move_done = (rem_reg == '0) && !wv_reg;

    assign result = result_reg;
    assign done   = done_reg;

    `SKT_CHECK(a_count_range, count_reg <= CNT_W'(TABLE_DEPTH), "entry count above depth")
    `SKT_CHECK(a_new_after_shift, cmd.write_new |-> (!wv_reg && !full_reg), "new entry write clash")
    `SKT_CHECK_NEXT(a_done_pulse, done_reg, !done_reg, "result strobe longer than one cycle")
    `SKT_CHECK_NEXT(a_count_hold, !(cmd.write_new || cmd.finish), $stable(count_reg), "count moved")

endmodule

FILE: src/skt_ctrl.sv
// ============================================================================
// skt_ctrl
// Sequencer of the sorted key table: search, shift, scan and finish steps.
// ============================================================================
module skt_ctrl
    import skt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] op_in,
    input  skt_stat_t stat,
    output skt_cmd_t  cmd,
    output logic      busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRCH   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op_in == OP_GROUP) ? S_SCAN : S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (stat.srch_more)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_CMP;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH;
            end
            S_DECIDE:
            begin
                state_next = S_FINISH;
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (!stat.hit && !stat.full)
                        begin
                            cmd.shift_up = 1'b1;
                            state_next   = S_SHIFT;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.shift_down = 1'b1;
                            state_next     = S_SHIFT;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (stat.move_done)
                begin
                    state_next = (stat.op == OP_INSERT) ? S_WRITE : S_FINISH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = S_FINISH;
            end
            S_SCAN:
            begin
                if (stat.move_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: src/sorted_key_table_with_group.sv
// ============================================================================
// sorted_key_table_with_group
// Table of unique keys kept in ascending order, each with a group tag.
// ============================================================================
// One command at a time: a transfer is taken when start is high and busy is
// low, and its result appears on result for exactly one cycle with done
// high; the receiver cannot stall, so it must capture result on that cycle.
// Entries live in a single-port-write, registered-read memory, so every
// binary search probe takes a read state and a compare state, and every
// shifted entry is read and then written back one place over. A search
// makes at most log2 of the count plus one probes; an insert that is taken
// then shifts the entries above its slot up and writes the new entry, a
// remove that hits shifts the entries above it down, and a group query
// scans every held entry. busy falls in the cycle done is shown, so
// the next command may start there. The entry count resets to zero; there
// is no memory clearing pass.
// ============================================================================
module sorted_key_table_with_group
    import skt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  skt_req_t request,
    output logic     done,
    output skt_res_t result
);

    skt_cmd_t  cmd;
    skt_stat_t stat;

    skt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op_in (request.command),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    skt_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .done    (done)
    );

endmodule

FILE: bench/sorted_key_table_with_group_tb.sv
// ============================================================================
// sorted_key_table_with_group_tb
// Self-checking bench for the sorted key table: a queue-fed command driver,
// a done-strobe monitor and a shadow table that predicts every result.
// ============================================================================
`timescale 1ns / 1ps

module sorted_key_table_with_group_tb
    import skt_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int QUIET_TAIL     = 150;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    skt_req_t request = '0;
    logic     done;
    skt_res_t result;

    skt_req_t cmd_queue[$];
    skt_res_t expected_results[$];
    logic [15:0] key_pool[$];

    // shadow copy of the table
    logic [KEY_BITS-1:0] tbl_key [TABLE_DEPTH];
    logic [TAG_W-1:0]    tbl_grp [TABLE_DEPTH];
    int                  tbl_count = 0;

    int fail_count  = 0;
    int idle_left   = 0;
    int idle_cycles = 0;

    sorted_key_table_with_group u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #1 clk = ~clk;

    function automatic skt_res_t table_apply(skt_req_t r);
        skt_res_t            res;
        logic [KEY_BITS-1:0] k;
        int                  lo;
        int                  hi;
        int                  mid;
        int                  idx;
        bit                  hit;
        res        = '0;
        res.status = ST_NOT_FOUND;
        k          = r.key[KEY_BITS-1:0];
        lo         = 0;
        hi         = tbl_count;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (tbl_key[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        idx = lo;
        hit = (idx < tbl_count) && (tbl_key[idx] == k);
        case (r.command)
            OP_INSERT:
            begin
                if (hit)
                begin
                    res.status   = ST_DUPLICATE;
                    res.position = idx[POS_W-1:0];
                end
                else if (tbl_count >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = tbl_count; i > idx; i--)
                    begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_grp[i] = tbl_grp[i-1];
                    end
                    tbl_key[idx] = k;
                    tbl_grp[idx] = r.group;
                    tbl_count++;
                    res.status   = ST_OK;
                    res.position = idx[POS_W-1:0];
                end
            end
            OP_LOOKUP:
            begin
                if (hit)
                begin
                    res.status    = ST_OK;
                    res.position  = idx[POS_W-1:0];
                    res.group_out = tbl_grp[idx];
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = idx; i + 1 < tbl_count; i++)
                    begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_grp[i] = tbl_grp[i+1];
                    end
                    tbl_count--;
                    res.status   = ST_OK;
                    res.position = idx[POS_W-1:0];
                end
            end
            default:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_grp[i] == r.group)
                    begin
                        res.status   = ST_OK;
                        res.position = i[POS_W-1:0];
                        break;
                    end
                end
            end
        endcase
        res.entries_held = tbl_count[HELD_W-1:0];
        return res;
    endfunction

    task automatic add_cmd(input logic [1:0] op, input logic [15:0] k, input logic [15:0] g);
        skt_req_t r;
        r.command = op;
        r.key     = k;
        r.group   = g;
        cmd_queue.push_back(r);
    endtask

    // pct percent of the time a key already used, else a fresh random one
    function automatic logic [15:0] pick_key(int pct);
        if (key_pool.size() > 0 && $urandom_range(0, 99) < pct)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // mostly a handful of tags so group queries hit
    function automatic logic [15:0] pick_group();
        if ($urandom_range(0, 99) < 70)
            return 16'($urandom_range(0, 7));
        return 16'($urandom_range(0, 65535));
    endfunction

    // driver: predicts on each accepted transfer, then offers the next command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            request   <= '0;
            idle_left  = 0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(table_apply(request));
            if (!start || !busy)
            begin
                if (idle_left == 0 && cmd_queue.size() > QUIET_TAIL
                    && $urandom_range(0, 3) == 0)
                    idle_left = $urandom_range(1, 5);
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    request <= cmd_queue.pop_front();
                    start   <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every done strobe must match the oldest expectation
    always @(posedge clk)
    begin
        skt_res_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                fail_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (result.status !== exp_res.status
                    || result.position !== exp_res.position
                    || result.group_out !== exp_res.group_out
                    || result.entries_held !== exp_res.entries_held)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_res, result);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int          sel;
        logic [15:0] k;
        // directed: empty table, extremes, duplicate, hits and misses
        add_cmd(OP_LOOKUP, 16'h0000, 16'h0000);
        add_cmd(OP_REMOVE, 16'hFFFF, 16'h0000);
        add_cmd(OP_GROUP,  16'h0000, 16'h0000);
        add_cmd(OP_INSERT, 16'h8000, 16'hFFFF);
        add_cmd(OP_INSERT, 16'h0000, 16'h0000);
        add_cmd(OP_INSERT, 16'hFFFF, 16'h1234);
        add_cmd(OP_INSERT, 16'h8000, 16'h5555);
        add_cmd(OP_INSERT, 16'hFFFF, 16'h0000);
        add_cmd(OP_LOOKUP, 16'h0000, 16'hFFFF);
        add_cmd(OP_LOOKUP, 16'hFFFF, 16'h0000);
        add_cmd(OP_LOOKUP, 16'h8000, 16'h0000);
        add_cmd(OP_LOOKUP, 16'h0005, 16'h0000);
        add_cmd(OP_GROUP,  16'h0000, 16'hFFFF);
        add_cmd(OP_GROUP,  16'hFFFF, 16'h0000);
        add_cmd(OP_GROUP,  16'h0000, 16'h5555);
        add_cmd(OP_REMOVE, 16'h0000, 16'h0000);
        add_cmd(OP_REMOVE, 16'h0000, 16'h0000);
        add_cmd(OP_LOOKUP, 16'h8000, 16'h0000);
        add_cmd(OP_REMOVE, 16'hFFFF, 16'hFFFF);
        add_cmd(OP_REMOVE, 16'h8000, 16'h0000);
        add_cmd(OP_LOOKUP, 16'h8000, 16'h0000);

        // fill: 128 distinct keys, then more inserts to hit the full case
        for (int i = 0; i < 140; i++)
        begin
            if (i < TABLE_DEPTH)
                k = 16'((i << 9) | $urandom_range(0, 511));
            else
                k = pick_key(30);
            key_pool.push_back(k);
            add_cmd(OP_INSERT, k, pick_group());
        end
        // traffic on the full table
        for (int i = 0; i < 40; i++)
        begin
            sel = $urandom_range(0, 3);
            add_cmd(2'(sel), pick_key(70), pick_group());
        end
        // drain: remove every key in the pool; keys inserted by the traffic above are not pooled
        foreach (key_pool[i])
            add_cmd(OP_REMOVE, key_pool[i], 16'($urandom_range(0, 65535)));
        for (int i = 0; i < 10; i++)
            add_cmd(2'($urandom_range(1, 3)), pick_key(50), pick_group());

        // mixed traffic
        for (int i = 0; i < 1150; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                k = pick_key(40);
                key_pool.push_back(k);
                add_cmd(OP_INSERT, k, pick_group());
            end
            else if (sel < 60)
                add_cmd(OP_LOOKUP, pick_key(75), 16'($urandom_range(0, 65535)));
            else if (sel < 85)
                add_cmd(OP_REMOVE, pick_key(75), 16'($urandom_range(0, 65535)));
            else
                add_cmd(OP_GROUP, pick_key(0), pick_group());
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sorted_key_table_with_group.f
+incdir+src
src/skt_pkg.sv
src/skt_dpath.sv
src/skt_ctrl.sv
src/sorted_key_table_with_group.sv
bench/sorted_key_table_with_group_tb.sv
